// File: rtl/dslp_pkg.sv
// Package with the shared constants, state type and control structs of the label placer.
`timescale 1ns / 1ps
`default_nettype none
package dslp_pkg;

  localparam int DEPTH_W            = 24;
  localparam int LIDX_W             = 6;
  localparam int BATCH_DEPTH_DEF    = 64;
  localparam int PLACED_DEPTH_DEF   = 128;
  localparam int COORD_WIDTH_DEF    = 20;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_KEY,
    ST_RK_LATCH,
    ST_RK_SCAN,
    ST_RK_WR,
    ST_RS_ORD,
    ST_RS_ORDW,
    ST_RS_EDGE,
    ST_RS_SCAN,
    ST_RS_EMIT
  } dslp_state_t;

  typedef struct packed {
    logic load;
    logic rk_key;
    logic rk_latch;
    logic rk_scan;
    logic rk_wr;
    logic rs_ordw;
    logic rs_edge;
    logic rs_scan;
    logic rs_emit;
  } dslp_cmd_t;

  typedef struct packed {
    logic batch_start;
    logic rk_done;
    logic rk_last;
    logic rs_done;
    logic out_free;
    logic batch_last;
  } dslp_stat_t;

endpackage
`default_nettype wire

// File: rtl/depth_sorted_label_placer.sv
// Top level of the depth-sorted greedy label placer.
`timescale 1ns / 1ps
`default_nettype none
// Candidate boxes load one word per cycle while the block is idle; a clear word empties the
// placed set. The candidate with tlast starts resolution of n held candidates, during which
// in_tready is low. Ranking is bound by the single read port of the depth memory that each
// rank count scans. Each result then waits on the scan of the placed-box memory. The block
// takes words again as soon as the last result of the batch sits in the output register.
module depth_sorted_label_placer
  import dslp_pkg::*;
#(
  parameter int BATCH_DEPTH  = BATCH_DEPTH_DEF,
  parameter int PLACED_DEPTH = PLACED_DEPTH_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // depth, left_x, top_y, right_x, bottom_y, then zero padding
  input  wire logic [((DEPTH_W + 4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic in_tlast,  // batch_end
  input  wire logic in_tuser,  // req_type
  output logic      out_tvalid,
  input  wire logic out_tready,
  // arrival index, visible, then zero padding
  output logic [7:0] out_tdata,
  output logic      out_tlast  // final_result
);

  localparam int IN_DATA_W = ((DEPTH_W + 4 * COORD_WIDTH + 7) / 8) * 8;

  dslp_cmd_t         cmd;
  dslp_stat_t        stat;
  logic [LIDX_W-1:0] out_index;
  logic              out_visible;

  dslp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  dslp_dp #(
    .BATCH_DEPTH  (BATCH_DEPTH),
    .PLACED_DEPTH (PLACED_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH),
    .IN_DATA_W    (IN_DATA_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tvalid   (in_tvalid),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_index   (out_index),
    .out_visible (out_visible),
    .out_last    (out_tlast)
  );

  assign in_tready = cmd.load;
  assign out_tdata = {1'b0, out_visible, out_index};

endmodule
`default_nettype wire

// File: rtl/dslp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dslp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/dslp_ctrl.sv
// Controller state machine that sequences loading, ranking and resolution of a batch.
`timescale 1ns / 1ps
`default_nettype none
module dslp_ctrl
  import dslp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dslp_stat_t stat,
  output dslp_cmd_t       cmd
);

  dslp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (stat.batch_start) state_nxt = ST_RK_KEY;
      end
      ST_RK_KEY: begin
        cmd.rk_key = 1'b1;
        state_nxt  = ST_RK_LATCH;
      end
      ST_RK_LATCH: begin
        cmd.rk_latch = 1'b1;
        state_nxt    = ST_RK_SCAN;
      end
      ST_RK_SCAN: begin
        cmd.rk_scan = 1'b1;
        if (stat.rk_done) state_nxt = ST_RK_WR;
      end
      ST_RK_WR: begin
        cmd.rk_wr = 1'b1;
        state_nxt = stat.rk_last ? ST_RS_ORD : ST_RK_KEY;
      end
      ST_RS_ORD: begin
        state_nxt  = ST_RS_ORDW;
      end
      ST_RS_ORDW: begin
        cmd.rs_ordw = 1'b1;
        state_nxt   = ST_RS_EDGE;
      end
      ST_RS_EDGE: begin
        cmd.rs_edge = 1'b1;
        state_nxt   = ST_RS_SCAN;
      end
      ST_RS_SCAN: begin
        cmd.rs_scan = 1'b1;
        if (stat.rs_done) state_nxt = ST_RS_EMIT;
      end
      ST_RS_EMIT: begin
        cmd.rs_emit = 1'b1;
        if (stat.out_free) begin
          state_nxt = stat.batch_last ? ST_LOAD : ST_RS_ORD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/dslp_dp.sv
// Datapath with the batch and placed-box memories, rank counter, overlap test and output register.
`timescale 1ns / 1ps
`default_nettype none
module dslp_dp
  import dslp_pkg::*;
#(
  parameter int BATCH_DEPTH  = BATCH_DEPTH_DEF,
  parameter int PLACED_DEPTH = PLACED_DEPTH_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int IN_DATA_W    = 104
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dslp_cmd_t            cmd,
  output dslp_stat_t                stat,
  input  wire logic                 in_tvalid,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tlast,
  input  wire logic                 in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [LIDX_W-1:0]         out_index,
  output logic                      out_visible,
  output logic                      out_last
);

  localparam int IW  = $clog2(BATCH_DEPTH);
  localparam int CW  = $clog2(BATCH_DEPTH + 1);
  localparam int PW  = $clog2(PLACED_DEPTH);
  localparam int PCW = $clog2(PLACED_DEPTH + 1);
  localparam int EW  = 4 * COORD_WIDTH;

  logic [CW-1:0]      pend_cnt_r, i_r, j_r, k_r, rank_r, lag_j_r;
  logic [PCW-1:0]     placed_cnt_r, p_r;
  logic               lag_v_r, hit_r;
  logic [DEPTH_W-1:0] key_r;
  logic [IW-1:0]      idx_r;
  logic [EW-1:0]      box_r;
  logic               out_valid_r, out_vis_r, out_last_r;
  logic [LIDX_W-1:0]  out_idx_r;

  logic               accept, pend_we, placed_we, emit, visible_now;
  logic [EW-1:0]      in_box;
  logic [DEPTH_W-1:0] d_rdata;
  logic [IW-1:0]      s_rdata;
  logic [EW-1:0]      e_rdata, p_rdata;
  logic               overlap, key_after;

  assign accept = cmd.load && in_tvalid;
  assign pend_we = accept && !in_tuser && (pend_cnt_r < CW'(BATCH_DEPTH));
  // Edges are stored as {bottom, top, right, left}.
  assign in_box = {in_tdata[DEPTH_W+3*COORD_WIDTH +: COORD_WIDTH],
                   in_tdata[DEPTH_W+COORD_WIDTH +: COORD_WIDTH],
                   in_tdata[DEPTH_W+2*COORD_WIDTH +: COORD_WIDTH],
                   in_tdata[DEPTH_W +: COORD_WIDTH]};

  dslp_ram #(.WIDTH(DEPTH_W), .DEPTH(BATCH_DEPTH)) u_depth_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_cnt_r[IW-1:0]),
    .wdata (in_tdata[DEPTH_W-1:0]),
    .raddr (cmd.rk_key ? i_r[IW-1:0] : j_r[IW-1:0]),
    .rdata (d_rdata)
  );

  dslp_ram #(.WIDTH(EW), .DEPTH(BATCH_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_cnt_r[IW-1:0]),
    .wdata (in_box),
    .raddr (s_rdata),
    .rdata (e_rdata)
  );

  dslp_ram #(.WIDTH(IW), .DEPTH(BATCH_DEPTH)) u_order_ram (
    .clk   (clk),
    .we    (cmd.rk_wr),
    .waddr (rank_r[IW-1:0]),
    .wdata (i_r[IW-1:0]),
    .raddr (k_r[IW-1:0]),
    .rdata (s_rdata)
  );

  assign emit        = cmd.rs_emit && (!out_valid_r || out_tready);
  assign visible_now = !hit_r;
  assign placed_we   = emit && visible_now && (placed_cnt_r < PCW'(PLACED_DEPTH));

  dslp_ram #(.WIDTH(EW), .DEPTH(PLACED_DEPTH)) u_placed_ram (
    .clk   (clk),
    .we    (placed_we),
    .waddr (placed_cnt_r[PW-1:0]),
    .wdata (box_r),
    .raddr (p_r[PW-1:0]),
    .rdata (p_rdata)
  );

  // Stable order: an earlier entry with an equal depth ranks ahead.
  assign key_after = (d_rdata < key_r) || ((d_rdata == key_r) && (lag_j_r < i_r));

  // Strict overlap of the held box against one placed box.
  assign overlap =
    ($signed(box_r[0 +: COORD_WIDTH]) < $signed(p_rdata[COORD_WIDTH +: COORD_WIDTH])) &&
    ($signed(box_r[COORD_WIDTH +: COORD_WIDTH]) > $signed(p_rdata[0 +: COORD_WIDTH])) &&
    ($signed(box_r[2*COORD_WIDTH +: COORD_WIDTH]) <
     $signed(p_rdata[3*COORD_WIDTH +: COORD_WIDTH])) &&
    ($signed(box_r[3*COORD_WIDTH +: COORD_WIDTH]) >
     $signed(p_rdata[2*COORD_WIDTH +: COORD_WIDTH]));

  always_comb begin
    stat.batch_start = accept && !in_tuser && in_tlast;
    stat.rk_done     = (j_r >= pend_cnt_r) && !lag_v_r;
    stat.rk_last     = (i_r + CW'(1)) == pend_cnt_r;
    stat.rs_done     = (p_r >= placed_cnt_r) && !lag_v_r;
    stat.out_free    = !out_valid_r || out_tready;
    stat.batch_last  = (k_r + CW'(1)) == pend_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r   <= '0;
      placed_cnt_r <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      p_r          <= '0;
      rank_r       <= '0;
      lag_v_r      <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !emit) out_valid_r <= 1'b0;

      if (accept && in_tuser) placed_cnt_r <= '0;
      if (pend_we) pend_cnt_r <= pend_cnt_r + CW'(1);
      if (stat.batch_start) begin
        i_r <= '0;
        k_r <= '0;
      end

      if (cmd.rk_latch) begin
        j_r     <= '0;
        rank_r  <= '0;
        lag_v_r <= 1'b0;
      end
      if (cmd.rk_scan) begin
        lag_v_r <= j_r < pend_cnt_r;
        lag_j_r <= j_r;
        if (j_r < pend_cnt_r) j_r <= j_r + CW'(1);
        if (lag_v_r && key_after) rank_r <= rank_r + CW'(1);
      end
      if (cmd.rk_wr) i_r <= i_r + CW'(1);

      if (cmd.rs_edge) begin
        p_r     <= '0;
        hit_r   <= 1'b0;
        lag_v_r <= 1'b0;
      end
      if (cmd.rs_scan) begin
        lag_v_r <= p_r < placed_cnt_r;
        if (p_r < placed_cnt_r) p_r <= p_r + PCW'(1);
        if (lag_v_r && overlap) hit_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        k_r         <= k_r + CW'(1);
        if (placed_we) placed_cnt_r <= placed_cnt_r + PCW'(1);
        if (stat.batch_last) pend_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rk_latch) key_r <= d_rdata;
    if (cmd.rs_ordw) idx_r <= s_rdata;
    if (cmd.rs_edge) box_r <= e_rdata;
    if (emit) begin
      out_idx_r  <= LIDX_W'(idx_r);
      out_vis_r  <= visible_now;
      out_last_r <= stat.batch_last;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_index   = out_idx_r;
  assign out_visible = out_vis_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// File: dv/tb_depth_sorted_label_placer.sv
// Self-checking testbench for the depth-sorted greedy label placer.
`timescale 1ns / 1ps
module tb_depth_sorted_label_placer;
  import dslp_pkg::*;

  localparam int BATCH = 64;
  localparam int PLACED = 128;
  localparam int CW = 20;
  localparam int DW = ((DEPTH_W + 4 * CW + 7) / 8) * 8;
  localparam logic REQ_BOX = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [LIDX_W-1:0] arrival_idx;
    logic              visible;
    logic              final_result;
  } label_res_t;

  typedef struct {
    logic [DEPTH_W-1:0]  depth;
    logic signed [CW-1:0] l, t, r, b;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;

  box_t       held_boxes[$];
  box_t       placed_boxes[$];
  label_res_t expected_labels[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  depth_sorted_label_placer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit overlaps(box_t a, box_t p);
    return a.l < p.r && a.r > p.l && a.t < p.b && a.b > p.t;
  endfunction

  function automatic void predict_word(logic req, box_t bx, logic last);
    int order[$];
    int j;
    int idx;
    bit vis;
    label_res_t res;
    if (req == REQ_CLEAR) begin
      placed_boxes.delete();
      return;
    end
    if (held_boxes.size() < BATCH) held_boxes.push_back(bx);
    if (!last) return;
    for (int i = 0; i < held_boxes.size(); i++) begin
      j = order.size();
      while (j > 0 && held_boxes[order[j-1]].depth > held_boxes[i].depth) j--;
      order.insert(j, i);
    end
    for (int k = 0; k < order.size(); k++) begin
      idx = order[k];
      vis = 1'b1;
      foreach (placed_boxes[p]) if (overlaps(held_boxes[idx], placed_boxes[p])) vis = 1'b0;
      if (vis && placed_boxes.size() < PLACED) placed_boxes.push_back(held_boxes[idx]);
      res.arrival_idx = idx[LIDX_W-1:0];
      res.visible = vis;
      res.final_result = (k == order.size() - 1);
      expected_labels.push_back(res);
    end
    held_boxes.delete();
  endfunction

  task automatic send_word(logic req, box_t bx, logic last);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tlast <= last;
    in_tdata <= DW'({bx.b, bx.r, bx.t, bx.l, bx.depth});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(req, bx, last);
  endtask

  function automatic box_t rand_box(int span);
    box_t bx;
    int x, y;
    bx.depth = DEPTH_W'($urandom());
    if (span == 0) begin
      bx.l = CW'($urandom()); bx.t = CW'($urandom());
      bx.r = CW'($urandom()); bx.b = CW'($urandom());
    end else begin
      x = int'($urandom_range(4000)) - 2000;
      y = int'($urandom_range(4000)) - 2000;
      bx.l = CW'(x); bx.t = CW'(y);
      bx.r = CW'(x + int'($urandom_range(span)));
      bx.b = CW'(y + int'($urandom_range(span)));
    end
    return bx;
  endfunction

  function automatic box_t mk(int d, int l, int t, int r, int b);
    box_t bx;
    bx.depth = DEPTH_W'(d); bx.l = CW'(l); bx.t = CW'(t); bx.r = CW'(r); bx.b = CW'(b);
    return bx;
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_labels.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    box_t z;
    z = mk(0, 0, 0, 0, 0);
    send_word(REQ_CLEAR, z, 1'b1);
    send_word(REQ_BOX, mk(5, 0, 0, 16, 16), 1'b0);
    send_word(REQ_BOX, mk(5, 16, 0, 32, 16), 1'b0);
    send_word(REQ_BOX, mk(2, 8, 8, 24, 24), 1'b0);
    send_word(REQ_BOX, mk(24'hFFFFFF, -524288, -524288, 524287, 524287), 1'b0);
    send_word(REQ_BOX, mk(0, 100, 100, 50, 50), 1'b0);
    send_word(REQ_BOX, mk(5, 0, 16, 16, 32), 1'b1);
    send_word(REQ_CLEAR, mk(24'hFFFFFF, -1, -1, -1, -1), 1'b1);
    send_word(REQ_BOX, mk(24'hFFFFFF, 524287, 524287, -524288, -524288), 1'b1);
    send_word(REQ_CLEAR, z, 1'b0);
    drain();
  endtask

  // Disjoint boxes, so every held candidate is placed and the two extra ones are dropped.
  task automatic test_full_batch();
    for (int i = 0; i < BATCH + 2; i++)
      send_word(REQ_BOX, mk($urandom_range(3), i * 32, 0, i * 32 + 16, 16), i == BATCH + 1);
    drain();
  endtask

  // Continues from the placed set left by the full batch and runs it past capacity; the
  // last word repeats a box that was visible but not placed, so it is visible again.
  task automatic test_placed_full();
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < 33; i++)
        send_word(REQ_BOX, mk(i, (k * 33 + i) * 16, 64, (k * 33 + i) * 16 + 8, 72),
                  i == 32);
    send_word(REQ_BOX, mk(0, 65 * 16, 64, 65 * 16 + 8, 72), 1'b1);
    drain();
  endtask

  task automatic test_random(int n);
    int left;
    int len;
    left = n;
    send_word(REQ_CLEAR, rand_box(0), 1'b0);
    while (left > 0) begin
      len = $urandom_range(8, 1);
      if ($urandom_range(9) == 0) send_word(REQ_CLEAR, rand_box(0), 1'($urandom_range(1)));
      for (int i = 0; i < len && left > 0; i++, left--)
        send_word(REQ_BOX, rand_box($urandom_range(3) == 0 ? 0 : 600),
                  i == len - 1 || left == 1);
      if ($urandom_range(7) == 0) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    label_res_t got, want;
    if (rst_n) begin
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ? 0
                                                                            : idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.arrival_idx = out_tdata[LIDX_W-1:0];
        got.visible = out_tdata[LIDX_W];
        got.final_result = out_tlast;
        if (expected_labels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected word: got %p", got);
        end else begin
          want = expected_labels.pop_front();
          if (got !== want || out_tdata[7] !== 1'b0) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 8;
    recv_stall_pct = 72;
    test_directed();
    test_full_batch();
    send_gap_pct = 72;
    recv_stall_pct = 8;
    test_placed_full();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(20);
    drain();
    if (errors == 0 && expected_labels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/dslp_pkg.sv
rtl/dslp_ram.sv
rtl/dslp_ctrl.sv
rtl/dslp_dp.sv
rtl/depth_sorted_label_placer.sv
dv/tb_depth_sorted_label_placer.sv
